// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

// ===== src/fpm_pkg.sv =====
// Package: constants and command/status types for the polynomial multiplier.
package fpm_pkg;
   localparam int MaxTerms = 32;
   localparam int IdxW = $clog2(MaxTerms);
   localparam int CntW = IdxW + 1;
   localparam int KW = IdxW + 1;
   localparam int CoefW = 37;

   typedef enum logic [2:0] {
      ST_LOAD, ST_CLEAR, ST_MAC, ST_STORE, ST_SCAN, ST_EMIT
   } state_type;

   typedef struct packed {
      logic          clear_acc;
      logic          mac_en;
      logic [IdxW-1:0] ia;
      logic [IdxW-1:0] ib;
      logic          store;
      logic [KW-1:0] k;
      logic          load;
      logic          rd_en;
   } cmd_type;

   typedef struct packed {
      logic          nonzero;
      logic [KW-1:0] top;
      logic          any;
   } stat_type;
endpackage

// ===== src/fpm_datapath.sv =====
// Datapath: operand stores, multiply-accumulate and result memory.
module fpm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  fpm_pkg::cmd_type              cmd,
   input  logic signed [15:0]            a_in,
   input  logic signed [15:0]            b_in,
   input  logic [fpm_pkg::IdxW-1:0]      wr_idx,
   input  logic [fpm_pkg::KW-1:0]        rd_k,
   output logic signed [fpm_pkg::CoefW-1:0] rd_coef,
   output fpm_pkg::stat_type             stat
);
   logic signed [15:0] a_mem [fpm_pkg::MaxTerms];
   logic signed [15:0] b_mem [fpm_pkg::MaxTerms];
   logic signed [fpm_pkg::CoefW-1:0] r_mem [2*fpm_pkg::MaxTerms];
   logic signed [15:0] a_rd_ff, b_rd_ff;
   logic signed [31:0] prod_ff;
   logic prod_v_ff;
   logic signed [fpm_pkg::CoefW-1:0] acc_ff, acc_in;
   logic [fpm_pkg::KW-1:0] top_ff;
   logic any_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_mem[wr_idx] <= a_in;
         b_mem[wr_idx] <= b_in;
      end
      a_rd_ff <= a_mem[cmd.ia];
      b_rd_ff <= b_mem[cmd.ib];
      prod_ff <= a_rd_ff * b_rd_ff;
      if (cmd.store) r_mem[cmd.k] <= acc_ff;
      if (cmd.rd_en) rd_coef <= r_mem[rd_k];
   end

   logic mac_d1_ff;
   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear_acc) acc_in = '0;
      else if (prod_v_ff) acc_in = acc_ff + fpm_pkg::CoefW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_d1_ff <= 1'b0;
         prod_v_ff <= 1'b0;
         acc_ff <= '0;
         top_ff <= '0;
         any_ff <= 1'b0;
      end else begin
         mac_d1_ff <= cmd.mac_en;
         prod_v_ff <= mac_d1_ff;
         acc_ff <= acc_in;
         if (cmd.clear_acc && cmd.k == '0) begin
            any_ff <= 1'b0;
            top_ff <= '0;
         end
         if (cmd.store && acc_ff != '0) begin
            any_ff <= 1'b1;
            top_ff <= cmd.k;
         end
      end
   end

   assign stat.nonzero = acc_ff != '0;
   assign stat.top = top_ff;
   assign stat.any = any_ff;
endmodule

// ===== src/fpm_control.sv =====
// Controller: load counting and convolution / emit sequencing.
module fpm_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       rsp_tuser_last,
   output fpm_pkg::cmd_type           cmd,
   output logic [fpm_pkg::IdxW-1:0]   wr_idx,
   output logic [fpm_pkg::KW-1:0]     rd_k,
   input  fpm_pkg::stat_type          stat
);
   fpm_pkg::state_type st_ff, st_in;
   logic [fpm_pkg::CntW-1:0] n_ff, n_in;
   logic [fpm_pkg::KW-1:0] k_ff, k_in, top_ff, top_in;
   logic [fpm_pkg::IdxW-1:0] i_ff, i_in, hi_ff, hi_in;
   logic [2:0] w_ff, w_in;
   logic rv_ff, rv_in, rl_ff, rl_in, pend_ff, pend_in;
   logic [fpm_pkg::KW:0] lo_w;
   logic [fpm_pkg::KW:0] len;
   logic fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= fpm_pkg::ST_LOAD;
         n_ff <= '0; k_ff <= '0; i_ff <= '0; hi_ff <= '0; w_ff <= '0;
         top_ff <= '0; rv_ff <= 1'b0; rl_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; k_ff <= k_in; i_ff <= i_in;
         hi_ff <= hi_in; w_ff <= w_in; top_ff <= top_in;
         rv_ff <= rv_in; rl_ff <= rl_in; pend_ff <= pend_in;
      end
   end

   assign len = {n_ff, 1'b0} - 1'b1;
   assign fire = req_tvalid && req_tready;

   always_comb begin
      st_in = st_ff; n_in = n_ff; k_in = k_ff; i_in = i_ff; hi_in = hi_ff;
      w_in = w_ff; top_in = top_ff; rv_in = rv_ff; rl_in = rl_ff; pend_in = pend_ff;
      cmd = '0;
      cmd.k = k_ff;
      cmd.ia = i_ff;
      cmd.ib = fpm_pkg::IdxW'(k_ff - fpm_pkg::KW'(i_ff));
      wr_idx = n_ff[fpm_pkg::IdxW-1:0];
      rd_k = k_ff;
      req_tready = 1'b0;
      lo_w = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (st_ff)
         fpm_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (fire) begin
               if (n_ff < fpm_pkg::CntW'(fpm_pkg::MaxTerms)) begin
                  cmd.load = 1'b1;
                  n_in = n_ff + 1'b1;
               end
               if (req_tlast) begin
                  st_in = fpm_pkg::ST_CLEAR;
                  k_in = '0;
               end
            end
         end
         fpm_pkg::ST_CLEAR: begin
            cmd.clear_acc = 1'b1;
            lo_w = ({1'b0, k_ff} >= {1'b0, n_ff}) ?
                   ({1'b0, k_ff} - {1'b0, n_ff} + 1'b1) : '0;
            i_in = lo_w[fpm_pkg::IdxW-1:0];
            hi_in = ({1'b0, k_ff} < {1'b0, n_ff}) ? k_ff[fpm_pkg::IdxW-1:0]
                   : fpm_pkg::IdxW'(n_ff - 1'b1);
            st_in = fpm_pkg::ST_MAC;
         end
         fpm_pkg::ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (i_ff == hi_ff) begin
               st_in = fpm_pkg::ST_STORE;
               w_in = 3'd3;
            end else i_in = i_ff + 1'b1;
         end
         fpm_pkg::ST_STORE: begin
            if (w_ff != '0) w_in = w_ff - 1'b1;
            else begin
               cmd.store = 1'b1;
               if ({1'b0, k_ff} == len - 1'b1) begin
                  st_in = fpm_pkg::ST_SCAN;
               end else begin
                  k_in = k_ff + 1'b1;
                  st_in = fpm_pkg::ST_CLEAR;
               end
            end
         end
         fpm_pkg::ST_SCAN: begin
            top_in = stat.top;
            k_in = '0;
            pend_in = 1'b0;
            st_in = fpm_pkg::ST_EMIT;
         end
         fpm_pkg::ST_EMIT: begin
            if (!pend_ff && (!rv_ff || rsp_tready)) begin
               cmd.rd_en = 1'b1;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
               rv_in = 1'b1;
               rl_in = (k_ff == top_ff);
               if (k_ff == top_ff) begin
                  st_in = fpm_pkg::ST_LOAD;
                  n_in = '0;
               end else k_in = k_ff + 1'b1;
            end
         end
         default: st_in = fpm_pkg::ST_LOAD;
      endcase
      rsp_tvalid = rv_ff;
      rsp_tuser_last = rl_ff;
   end
endmodule

// ===== src/fft_polynomial_multiply_core.sv =====
// Top level: integer polynomial multiplier with streaming ports.
//  channel | dir | data                       | last
//  req_    | in  | a_coef[15:0] b_coef[31:16] | tlast = last
//  rsp_    | out | coef[36:0] (zero-filled)   | tlast = last_res
// Load: one coefficient pair per cycle. Compute: per output k, the products in
// that sum go through one 16x16 multiply-accumulate; after the last k, a scan
// step; emit: each word is read from the result memory and then presented.
// Synchronous active-high reset; stalls on rsp_tready hold the result word.
module fft_polynomial_multiply_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // a_coef, b_coef
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // coef
   output logic        rsp_tlast    // last_res
);
   fpm_pkg::cmd_type cmd;
   fpm_pkg::stat_type stat;
   logic [fpm_pkg::IdxW-1:0] wr_idx;
   logic [fpm_pkg::KW-1:0] rd_k;
   logic signed [fpm_pkg::CoefW-1:0] coef;

   fpm_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tuser_last(rsp_tlast),
      .cmd, .wr_idx, .rd_k, .stat
   );
   fpm_datapath u_dp (
      .clock, .reset, .cmd,
      .a_in(req_tdata[15:0]), .b_in(req_tdata[31:16]),
      .wr_idx, .rd_k, .rd_coef(coef), .stat
   );
   assign rsp_tdata = {3'b000, coef};
endmodule

// ===== src/fpm_checker.sv =====
// Port-level checker bound to the top level.
`include "assert_macros.svh"
module fpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   `CHK_IMPLY(no_overlap, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)
   `CHK_NEXT(hold_word, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `CHK_IMPLY(pad_zero, clock, reset, rsp_tvalid, rsp_tdata[39:37] == 3'b000)
   `CHK_NEXT(last_done, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)
endmodule

bind fft_polynomial_multiply_core fpm_checker u_chk (.*);

// ===== dv/fft_polynomial_multiply_checker.sv =====
// Checker: predicts polynomial product coefficients and compares the result stream.
`timescale 1ns / 1ps
module fft_polynomial_multiply_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic [fpm_pkg::CoefW-1:0] coef;
      logic                      top;
   } product_word_type;

   longint           a_terms[fpm_pkg::MaxTerms];
   longint           b_terms[fpm_pkg::MaxTerms];
   int               loaded;
   product_word_type product_q[$];

   assign pending = product_q.size();

   task automatic load_pair(input logic [15:0] a, input logic [15:0] b, input logic fin);
      longint           acc;
      int               len;
      int               hi_k;
      product_word_type w;
      product_word_type prod[$];
      if (loaded < fpm_pkg::MaxTerms) begin
         a_terms[loaded] = longint'($signed(a));
         b_terms[loaded] = longint'($signed(b));
         loaded++;
      end
      if (fin) begin
         len = 2 * loaded - 1;
         hi_k = 0;
         for (int k = 0; k < len; k++) begin
            acc = 0;
            for (int i = 0; i < loaded; i++)
               if (k - i >= 0 && k - i < loaded) acc += a_terms[i] * b_terms[k - i];
            w.coef = acc[fpm_pkg::CoefW-1:0];
            w.top = 1'b0;
            prod.push_back(w);
            if (acc != 0) hi_k = k;
         end
         for (int k = 0; k <= hi_k; k++) begin
            w = prod[k];
            w.top = (k == hi_k);
            product_q.push_back(w);
         end
         loaded = 0;
         for (int i = 0; i < fpm_pkg::MaxTerms; i++) begin
            a_terms[i] = 0;
            b_terms[i] = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      product_word_type exp_w;
      if (reset) begin
         loaded = 0;
         fail_count <= 0;
         product_q.delete();
         for (int i = 0; i < fpm_pkg::MaxTerms; i++) begin
            a_terms[i] = 0;
            b_terms[i] = 0;
         end
      end else begin
         if (req_tvalid && req_tready)
            load_pair(req_tdata[15:0], req_tdata[31:16], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (product_q.size() == 0) begin
               $display("%0t: unexpected word coef=%0d last=%0b", $time,
                        $signed(rsp_tdata[fpm_pkg::CoefW-1:0]), rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = product_q.pop_front();
               if (rsp_tdata !== {3'b000, exp_w.coef} || rsp_tlast !== exp_w.top) begin
                  $display("%0t: expected coef=%0d last=%0b, actual coef=%0d data=%h last=%0b",
                           $time, $signed(exp_w.coef), exp_w.top,
                           $signed(rsp_tdata[fpm_pkg::CoefW-1:0]), rsp_tdata, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== dv/fft_polynomial_multiply_core_tb.sv =====
// Testbench top: drives coefficient pairs, throttles the result side, reports verdict.
`timescale 1ns / 1ps
module fft_polynomial_multiply_core_tb;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // a_coef, b_coef
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // coef
   logic        rsp_tlast;   // last_res
   int          fail_count;
   int          pending;
   int          cycle;
   bit          hold_off;
   bit          stim_done;

   localparam int CycleLimit = 2000000;

   fft_polynomial_multiply_core dut (.*);

   fft_polynomial_multiply_checker chk (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle <= reset ? 0 : cycle + 1;

   always @(posedge clock) begin
      if (cycle > CycleLimit) begin
         $display("fft_polynomial_multiply_core_tb: done, errors");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_coef(input int mode);
      case (mode)
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom());
      endcase
   endfunction

   // one word per accepted handshake; tready is stable between rising edges
   task automatic send_word(input logic [15:0] a, input logic [15:0] b, input logic fin);
      int g;
      bit accepted;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= fin;
      do begin
         accepted = req_tready;
         @(negedge clock);
      end while (!accepted);
   endtask

   task automatic send_poly(input int terms, input int mode);
      for (int i = 0; i < terms; i++)
         send_word(pick_coef(mode == 6 ? $urandom_range(0, 5) : mode),
                   pick_coef(mode == 6 ? $urandom_range(0, 5) : mode), i == terms - 1);
   endtask

   // receiver throttling, with one long hold-off
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_off = 0;
         end else if (!stim_done && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      int items;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      hold_off = 0;
      stim_done = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      // directed: single terms, extremes, zero product, overflow
      send_word(16'h7fff, 16'h7fff, 1'b1);
      send_word(16'h8000, 16'h8000, 1'b1);
      send_word(16'h8000, 16'h7fff, 1'b1);
      send_word(16'h0000, 16'h1234, 1'b1);
      send_poly(2, 2);
      send_poly(3, 0);
      send_poly(3, 1);
      send_word(16'h0003, 16'h0000, 1'b0);
      send_word(16'h0000, 16'h0005, 1'b1);
      send_word(16'h0001, 16'hffff, 1'b0);
      send_word(16'h0000, 16'h0000, 1'b1);
      hold_off = 1;
      send_poly(fpm_pkg::MaxTerms + 4, 0);
      send_poly(fpm_pkg::MaxTerms, 1);
      items = 0;
      while (items < 120) begin
         int n;
         int r;
         r = $urandom_range(0, 9);
         n = (r < 6) ? $urandom_range(1, 8)
           : (r < 9) ? $urandom_range(9, fpm_pkg::MaxTerms)
                     : $urandom_range(fpm_pkg::MaxTerms, fpm_pkg::MaxTerms + 3);
         send_poly(n, $urandom_range(0, 9) < 2 ? $urandom_range(0, 4) : 6);
         items += n;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      stim_done = 1;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0)
         $display("fft_polynomial_multiply_core_tb: done, clean");
      else
         $display("fft_polynomial_multiply_core_tb: done, errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+src
src/fpm_pkg.sv
src/fpm_datapath.sv
src/fpm_control.sv
src/fft_polynomial_multiply_core.sv
src/fpm_checker.sv
dv/fft_polynomial_multiply_checker.sv
dv/fft_polynomial_multiply_core_tb.sv
